// File: rtl/core/wheel_fault_monitor_defines.svh
// ----------------------------------------------------------------------------
// Wheel fault monitor assertion macros
// Shared concurrent assertion forms, clocked and gated by the async reset.
// ----------------------------------------------------------------------------
`ifndef WHEEL_FAULT_MONITOR_DEFINES_SVH
`define WHEEL_FAULT_MONITOR_DEFINES_SVH

// same-cycle implication
`define FWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/fwm_pkg.sv
// ----------------------------------------------------------------------------
// Wheel fault monitor package
// Shared widths, register indexes and wheel state codes.
// ----------------------------------------------------------------------------
package fwm_pkg;

	localparam int WHEEL_COUNT = 4;
	localparam int IDX_W       = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
	localparam int TIMER_W     = 24;
	localparam int RAM_W       = 2 * TIMER_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DUTY_THRESHOLD = 3'd0,
		REG_SPEED_FLOOR    = 3'd1,
		REG_STALL_CURRENT  = 3'd2,
		REG_FAULT_DEBOUNCE = 3'd3,
		REG_STALL_DEBOUNCE = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_LIMP  = 2'd1,
		ST_STALL = 2'd2
	} wheel_st_t;

endpackage

// File: rtl/core/fwm_if.sv
// ----------------------------------------------------------------------------
// Wheel fault monitor channels
// Sample input channel and status result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fwm_sample_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [1:0]         wheel;
	logic               drive_enabled;
	logic [15:0]        duty_magnitude;
	logic signed [15:0] wheel_speed;
	logic [15:0]        motor_current;
	logic [16:0]        step_time;

	modport source (output valid, cmd, wheel, drive_enabled, duty_magnitude,
		wheel_speed, motor_current, step_time, input ready);
	modport sink (input valid, cmd, wheel, drive_enabled, duty_magnitude,
		wheel_speed, motor_current, step_time, output ready);
endinterface

interface fwm_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] wheel_status;
	logic       any_stall;
	logic       any_limp;
	logic       red_led;
	logic       green_led;
	logic       led_changed;

	modport source (output valid, wheel_status, any_stall, any_limp, red_led,
		green_led, led_changed, input ready);
	modport sink (input valid, wheel_status, any_stall, any_limp, red_led,
		green_led, led_changed, output ready);
endinterface

// File: rtl/core/fwm_ram.sv
// ----------------------------------------------------------------------------
// Wheel fault monitor generic RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module fwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/wheel_fault_monitor.sv
// ----------------------------------------------------------------------------
// Wheel fault monitor
// Per-wheel OK / LIMP / STALL supervisor with debounce timers and status lamps.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries one transaction per control step: a clear command or a
//   sample of one wheel (duty, speed, current, elapsed time). result_ch
//   returns exactly one transaction per transaction taken: the addressed wheel's new
//   state, the any-stall / any-limp flags after the sample, and the lamp pair
//   derived from the flags before it, with a change flag.
//   Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// Timing:
//   A sample is taken every cycle while result_ch is not stalled. The per-wheel
//   timers live in a small RAM read at acceptance; the compute stage works on
//   the read data and its result lands in the output register. A write-back
//   colliding with the next read of the same wheel is forwarded.
// Reset / stall:
//   Reset puts every wheel in OK and the lamp code at zero; timers read as
//   zero through per-wheel valid bits, so no clearing pass is needed. When
//   result_ch stalls, the result holds, one more sample waits in the compute
//   stage, and sample_ch.ready drops.
// ----------------------------------------------------------------------------
`include "wheel_fault_monitor_defines.svh"

module wheel_fault_monitor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fwm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fwm_pkg::CFG_DATA_W-1:0]     cfg_data,
	fwm_sample_if.sink                         sample_ch,
	fwm_result_if.source                       result_ch
);

	localparam int NW = fwm_pkg::WHEEL_COUNT;
	localparam int IW = fwm_pkg::IDX_W;
	localparam int TW = fwm_pkg::TIMER_W;

	// ---------------- configuration registers ----------------
	logic [15:0]   duty_thr_q;
	logic [14:0]   speed_floor_q;
	logic [15:0]   stall_cur_q;
	logic [TW-1:0] fault_deb_q;
	logic [TW-1:0] stall_deb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_thr_q    <= 16'd9830;
			speed_floor_q <= 15'd20;
			stall_cur_q   <= 16'd2000;
			fault_deb_q   <= 24'd300000;
			stall_deb_q   <= 24'd300000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fwm_pkg::REG_DUTY_THRESHOLD: duty_thr_q    <= cfg_data[15:0];
				fwm_pkg::REG_SPEED_FLOOR:    speed_floor_q <= cfg_data[14:0];
				fwm_pkg::REG_STALL_CURRENT:  stall_cur_q   <= cfg_data[15:0];
				fwm_pkg::REG_FAULT_DEBOUNCE: fault_deb_q   <= cfg_data[TW-1:0];
				fwm_pkg::REG_STALL_DEBOUNCE: stall_deb_q   <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	logic s1_valid_q;
	logic out_valid_q;
	logic s1_adv;       // compute stage may hand its result to the output reg
	logic accept;

	assign s1_adv          = !out_valid_q || result_ch.ready;
	assign sample_ch.ready = !s1_valid_q || s1_adv;
	assign accept          = sample_ch.valid && sample_ch.ready;

	// ---------------- stage 1 payload ----------------
	logic          cmd_s1;
	logic [1:0]    wheel_s1;
	logic          en_s1;
	logic [15:0]   duty_s1;
	logic [15:0]   mag_s1;
	logic [15:0]   cur_s1;
	logic [16:0]   dt_s1;
	logic          byp_hit_s1;
	logic [fwm_pkg::RAM_W-1:0] byp_data_s1;

	logic [IW-1:0] rd_idx;
	logic [IW-1:0] idx_s1;
	logic [15:0]   speed_abs;

	assign rd_idx    = IW'(sample_ch.wheel);
	assign idx_s1    = IW'(wheel_s1);
	// |-32768| = 32768 still fits 16 bits unsigned
	assign speed_abs = sample_ch.wheel_speed[15] ? 16'(-sample_ch.wheel_speed)
		: 16'(sample_ch.wheel_speed);

	// RAM write-back from stage 1
	logic                      ram_we;
	logic [fwm_pkg::RAM_W-1:0] ram_wdata;
	logic [fwm_pkg::RAM_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			byp_hit_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			s1_valid_q <= sample_ch.valid;
			// same-wheel write on this edge: RAM returns old data, forward new
			byp_hit_s1 <= ram_we && (idx_s1 == rd_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= sample_ch.cmd;
			wheel_s1    <= sample_ch.wheel;
			en_s1       <= sample_ch.drive_enabled;
			duty_s1     <= sample_ch.duty_magnitude;
			mag_s1      <= speed_abs;
			cur_s1      <= sample_ch.motor_current;
			dt_s1       <= sample_ch.step_time;
			byp_data_s1 <= ram_wdata;
		end
	end

	fwm_ram #(
		.WIDTH (fwm_pkg::RAM_W),
		.DEPTH (NW)
	) u_timer_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (idx_s1),
		.wr_data (ram_wdata),
		.rd_en   (accept),
		.rd_addr (rd_idx),
		.rd_data (ram_rdata)
	);

	// ---------------- per-wheel flags, entry valid bits, lamp ----------------
	logic [NW-1:0] stall_q;
	logic [NW-1:0] limp_q;
	logic [NW-1:0] ent_valid_q;
	logic [1:0]    lamp_code_q;

	logic [NW-1:0] stall_nx;
	logic [NW-1:0] limp_nx;
	logic [NW-1:0] ent_valid_nx;
	logic [1:0]    lamp_nx;
	logic          red;
	logic          green;
	logic [1:0]    status;

	logic                in_range;
	logic                high;
	logic                locked;
	logic                still;
	logic [TW-1:0]       mt_cur;
	logic [TW-1:0]       st_cur;
	logic [TW-1:0]       mt_new;
	logic [TW-1:0]       st_new;
	logic [TW:0]         sum;
	logic [TW-1:0]       sum_sat;
	fwm_pkg::wheel_st_t  st_old;
	fwm_pkg::wheel_st_t  st_next;

	assign in_range = int'(wheel_s1) < NW;
	assign high     = duty_s1 > duty_thr_q;
	assign locked   = cur_s1 >= stall_cur_q;
	assign still    = mag_s1 < {1'b0, speed_floor_q};

	always_comb begin
		// timers: forwarded, stored, or never written since reset / clear
		if (byp_hit_s1) begin
			{mt_cur, st_cur} = byp_data_s1;
		end else if (ent_valid_q[idx_s1]) begin
			{mt_cur, st_cur} = ram_rdata;
		end else begin
			{mt_cur, st_cur} = '0;
		end

		priority if (stall_q[idx_s1]) begin
			st_old = fwm_pkg::ST_STALL;
		end else if (limp_q[idx_s1]) begin
			st_old = fwm_pkg::ST_LIMP;
		end else begin
			st_old = fwm_pkg::ST_OK;
		end

		// one shared saturating adder, fed by whichever timer the state runs
		sum     = {1'b0, (st_old == fwm_pkg::ST_LIMP) ? st_cur : mt_cur}
			+ (TW+1)'(dt_s1);
		sum_sat = sum[TW] ? '1 : sum[TW-1:0];

		mt_new  = mt_cur;
		st_new  = st_cur;
		st_next = st_old;
		unique case (st_old)
			fwm_pkg::ST_OK: begin
				if (high && still) begin
					if (sum_sat >= fault_deb_q) begin
						st_next = locked ? fwm_pkg::ST_STALL : fwm_pkg::ST_LIMP;
						mt_new  = '0;
					end else begin
						mt_new = sum_sat;
					end
				end else begin
					mt_new = '0;
				end
			end
			fwm_pkg::ST_LIMP: begin
				if (high && locked) begin
					if (sum_sat >= stall_deb_q) begin
						st_next = fwm_pkg::ST_STALL;
						st_new  = '0;
					end else begin
						st_new = sum_sat;
					end
				end else begin
					st_new = '0;
				end
			end
			default: ;  // stall is latched
		endcase

		ram_wdata = {mt_new, st_new};
		ram_we    = s1_valid_q && s1_adv && !cmd_s1 && en_s1 && in_range;

		// lamps from the flags before this transaction and the drive enable
		priority if (|stall_q) begin
			red = 1'b1; green = 1'b0;
		end else if (|limp_q) begin
			red = 1'b1; green = 1'b1;
		end else if (en_s1) begin
			red = 1'b0; green = 1'b1;
		end else begin
			red = 1'b1; green = 1'b0;
		end
		lamp_nx = {green, red};

		stall_nx     = stall_q;
		limp_nx      = limp_q;
		ent_valid_nx = ent_valid_q;
		if (cmd_s1) begin
			stall_nx     = '0;
			limp_nx      = '0;
			ent_valid_nx = '0;
		end else if (en_s1 && in_range) begin
			stall_nx[idx_s1]     = (st_next == fwm_pkg::ST_STALL);
			limp_nx[idx_s1]      = (st_next == fwm_pkg::ST_LIMP);
			ent_valid_nx[idx_s1] = 1'b1;
		end

		if (cmd_s1 || !in_range) begin
			status = fwm_pkg::ST_OK;
		end else if (en_s1) begin
			status = st_next;
		end else begin
			status = st_old;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_q     <= '0;
			limp_q      <= '0;
			ent_valid_q <= '0;
			lamp_code_q <= '0;
		end else if (s1_valid_q && s1_adv) begin
			stall_q     <= stall_nx;
			limp_q      <= limp_nx;
			ent_valid_q <= ent_valid_nx;
			lamp_code_q <= lamp_nx;
		end
	end

	// ---------------- output register ----------------
	logic [1:0] status_q;
	logic       any_stall_q;
	logic       any_limp_q;
	logic       red_q;
	logic       green_q;
	logic       changed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv) begin
			status_q    <= status;
			any_stall_q <= |stall_nx;
			any_limp_q  <= |limp_nx;
			red_q       <= red;
			green_q     <= green;
			changed_q   <= (lamp_nx != lamp_code_q);
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.wheel_status = status_q;
	assign result_ch.any_stall    = any_stall_q;
	assign result_ch.any_limp     = any_limp_q;
	assign result_ch.red_led      = red_q;
	assign result_ch.green_led    = green_q;
	assign result_ch.led_changed  = changed_q;

	// ---------------- assertions ----------------
	`FWM_ASSERT_NOW(a_flags_exclusive, clk, arst_n, 1'b1, (stall_q & limp_q) == '0,
		"wheel flagged both stall and limp")
	`FWM_ASSERT_NOW(a_we_only_on_adv, clk, arst_n, ram_we, s1_valid_q && s1_adv,
		"timer write-back without a retiring transaction")
	`FWM_ASSERT_NEXT(a_clear_empties, clk, arst_n, s1_valid_q && s1_adv && cmd_s1,
		stall_q == '0 && limp_q == '0 && ent_valid_q == '0,
		"clear command left a wheel flag or timer entry")
	`FWM_ASSERT_NOW(a_hold_blocks_input, clk, arst_n, s1_valid_q && !s1_adv,
		!sample_ch.ready, "input taken while compute stage is blocked")

endmodule
